### src/rsq_pkg.sv
// ----------------------------------------------------------------------------
// rsq_pkg: shared types and constants for the rotated sprite quad setup
// Request/response payloads, internal vertex records, register codes and the
// quarter-wave sine generator used to build the rotation table.
// ----------------------------------------------------------------------------
package rsq_pkg;

   localparam int unsigned CFG_W = 14;

   // register indexes
   localparam logic [1:0] CSR_VIEWPORT_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_VIEWPORT_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TEXTURE_WIDTH   = 2'd2;
   localparam logic [1:0] CSR_TEXTURE_HEIGHT  = 2'd3;

   localparam logic [CFG_W-1:0] VIEWPORT_WIDTH_RST  = 14'd1920;
   localparam logic [CFG_W-1:0] VIEWPORT_HEIGHT_RST = 14'd1080;
   localparam logic [CFG_W-1:0] TEXTURE_WIDTH_RST   = 14'd256;
   localparam logic [CFG_W-1:0] TEXTURE_HEIGHT_RST  = 14'd256;

   // corner codes: bit 0 selects right, bit 1 selects bottom
   localparam logic [1:0] CORNER_TL = 2'd0;
   localparam logic [1:0] CORNER_TR = 2'd1;
   localparam logic [1:0] CORNER_BL = 2'd2;
   localparam logic [1:0] CORNER_BR = 2'd3;

   // divider shape: numerator < divisor * 2^QUO_W
   localparam int unsigned DEN_W = 15;
   localparam int unsigned QUO_W = 17;
   localparam int unsigned NUM_W = DEN_W + QUO_W;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q14     = 64'd16384;

   typedef struct packed {
      logic signed [15:0] dest_x;
      logic signed [15:0] dest_y;
      logic [15:0]        dest_width;
      logic [15:0]        dest_height;
      logic [31:0]        color_rgba;
      logic [15:0]        rotation;
      logic [15:0]        src_x;
      logic [15:0]        src_y;
      logic [15:0]        src_width;
      logic [15:0]        src_height;
   } req_type;

   typedef struct packed {
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
      logic [31:0]        vertex_color;
      logic [15:0]        tex_u;
      logic [15:0]        tex_v;
      logic               last_vertex;
   } rsp_type;

   // effective (never zero) register values
   typedef struct packed {
      logic [CFG_W-1:0] vw;
      logic [CFG_W-1:0] vh;
      logic [CFG_W-1:0] tw;
      logic [CFG_W-1:0] th;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      req_type    sprite;
      logic [1:0] corner;
      logic       last;
   } vtx_type;

   typedef struct packed {
      logic             valid;
      logic [NUM_W-1:0] num_x;
      logic [NUM_W-1:0] num_y;
      logic [NUM_W-1:0] num_u;
      logic [NUM_W-1:0] num_v;
      logic [31:0]      color;
      logic             last;
   } num_type;

   // sin(k/Q * pi/2) in Q1.14, Q = 2^qbits; Taylor series to x^15 in Q30
   function automatic logic [63:0] quarter_sine(input int unsigned k,
                                                input int unsigned qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] r;
      x    = (64'(k) * HALF_PI_Q30) >> qbits;
      x2   = (x * x) >> 30;
      sum  = x;
      term = x;
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - term;
      r    = (sum + 64'd32768) >> 16;
      if (r > ONE_Q14) r = ONE_Q14;
      return r;
   endfunction

endpackage

### src/rsq_div_pipe.sv
// ----------------------------------------------------------------------------
// rsq_div_pipe: pipelined restoring divider
// One quotient bit per stage, MSB first. Caller keeps num < den * 2^QUO_W.
// ----------------------------------------------------------------------------
module rsq_div_pipe #(
   parameter int DEN_W = 15,
   parameter int QUO_W = 17
) (
   input  logic                   clock,
   input  logic                   advance,
   input  logic [DEN_W-1:0]       den,
   input  logic [DEN_W+QUO_W-1:0] num,
   output logic [QUO_W-1:0]       quo
);
   localparam int NUM_W = DEN_W + QUO_W;

   logic [NUM_W-1:0] rem_ff [QUO_W];
   logic [NUM_W-1:0] rem_in [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [QUO_W-1:0] quo_in [QUO_W];

   always_comb begin
      logic [NUM_W-1:0] rem_prev;
      logic [QUO_W-1:0] quo_prev;
      logic [NUM_W-1:0] shifted;
      logic [NUM_W:0]   diff;
      for (int i = 0; i < QUO_W; i++) begin
         rem_prev = (i == 0) ? num : rem_ff[(i == 0) ? 0 : i - 1];
         quo_prev = (i == 0) ? '0 : quo_ff[(i == 0) ? 0 : i - 1];
         shifted  = NUM_W'(den) << (QUO_W - 1 - i);
         diff     = {1'b0, rem_prev} - {1'b0, shifted};
         if (!diff[NUM_W]) begin
            rem_in[i] = diff[NUM_W-1:0];
            quo_in[i] = quo_prev | (QUO_W'(1) << (QUO_W - 1 - i));
         end else begin
            rem_in[i] = rem_prev;
            quo_in[i] = quo_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

### src/rsq_expand.sv
// ----------------------------------------------------------------------------
// rsq_expand: sprite to vertex sequencer
// Holds one sprite and issues its six vertices TL, TR, BL, BL, TR, BR.
// ----------------------------------------------------------------------------
module rsq_expand (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             req_valid,
   output logic             req_stall,
   input  rsq_pkg::req_type req_data,
   output rsq_pkg::vtx_type vtx
);
   import rsq_pkg::*;

   localparam logic [2:0] LAST_SLOT = 3'd5;

   logic       busy_ff, busy_in;
   logic [2:0] slot_ff, slot_in;
   req_type    sprite_ff, sprite_in;
   logic       take;

   // a new sprite enters as the last vertex of the current one leaves
   assign req_stall = !(advance && (!busy_ff || slot_ff == LAST_SLOT));
   assign take      = req_valid && !req_stall;

   always_comb begin
      busy_in   = busy_ff;
      slot_in   = slot_ff;
      sprite_in = sprite_ff;
      if (take) begin
         busy_in   = 1'b1;
         slot_in   = 3'd0;
         sprite_in = req_data;
      end else if (advance && busy_ff) begin
         if (slot_ff == LAST_SLOT) begin
            busy_in = 1'b0;
         end else begin
            slot_in = slot_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         slot_ff <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         slot_ff <= slot_in;
      end
      sprite_ff <= sprite_in;
   end

   always_comb begin
      vtx.valid  = busy_ff;
      vtx.sprite = sprite_ff;
      vtx.last   = (slot_ff == LAST_SLOT);
      unique case (slot_ff)
         3'd0:    vtx.corner = CORNER_TL;
         3'd1:    vtx.corner = CORNER_TR;
         3'd2:    vtx.corner = CORNER_BL;
         3'd3:    vtx.corner = CORNER_BL;
         3'd4:    vtx.corner = CORNER_TR;
         3'd5:    vtx.corner = CORNER_BR;
         default: vtx.corner = CORNER_TL;
      endcase
   end

endmodule

### src/rsq_geom.sv
// ----------------------------------------------------------------------------
// rsq_geom: rotation and numerator setup, five stages
// Table lookup, products, corner sums, rounding bias and saturation clamp,
// leaving non-negative numerators for the dividers.
// ----------------------------------------------------------------------------
module rsq_geom #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int OUT_FRAC_BITS   = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  rsq_pkg::cfg_type cfg,
   input  rsq_pkg::vtx_type vtx_in,
   output rsq_pkg::num_type num_out
);
   import rsq_pkg::*;

   localparam int QBITS     = SINE_TABLE_BITS - 2;
   localparam int QN        = 1 << QBITS;
   localparam int IDX_W     = QBITS + 1;
   localparam int PH_W      = SINE_TABLE_BITS;
   localparam int RND_SHIFT = 16 - SINE_TABLE_BITS;
   localparam int SCALE_SH  = OUT_FRAC_BITS + 1;

   // quarter-wave table, 0..QN-1; the end point sin(pi/2) stands apart
   localparam logic [14:0] SINE_PEAK = 15'(quarter_sine(QN, QBITS));

   logic [14:0] sine_lut [QN];
   for (genvar k = 0; k < QN; k++) begin : g_lut
      assign sine_lut[k] = 15'(quarter_sine(k, QBITS));
   end

   // ---- stage 1: sine/cosine, centre and offsets
   logic               s1_valid_ff;
   logic signed [15:0] s1_sin_ff, s1_cos_ff;
   logic signed [17:0] s1_cx2_ff, s1_cy2_ff;
   logic signed [16:0] s1_ox_ff, s1_oy_ff;
   logic [16:0]        s1_su_ff, s1_sv_ff;
   logic [31:0]        s1_color_ff;
   logic               s1_last_ff;

   logic [16:0]        rot_sum;
   logic [PH_W-1:0]    phase [2];
   logic signed [15:0] trig [2];
   logic signed [16:0] dwz, dhz;

   always_comb begin
      logic [1:0]       quad;
      logic [QBITS-1:0] rem;
      logic [IDX_W-1:0] idx;
      logic [14:0]      mag;
      rot_sum  = {1'b0, vtx_in.sprite.rotation} + 17'(1 << (RND_SHIFT - 1));
      phase[0] = PH_W'(rot_sum >> RND_SHIFT);
      phase[1] = phase[0] + PH_W'(QN);
      for (int i = 0; i < 2; i++) begin
         quad    = phase[i][PH_W-1 -: 2];
         rem     = phase[i][QBITS-1:0];
         idx     = quad[0] ? (IDX_W'(QN) - {1'b0, rem}) : {1'b0, rem};
         mag     = idx[QBITS] ? SINE_PEAK : sine_lut[idx[QBITS-1:0]];
         trig[i] = quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
      end
      dwz = signed'({1'b0, vtx_in.sprite.dest_width});
      dhz = signed'({1'b0, vtx_in.sprite.dest_height});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= vtx_in.valid;
      end
      if (advance) begin
         s1_sin_ff   <= trig[0];
         s1_cos_ff   <= trig[1];
         s1_cx2_ff   <= (18'(vtx_in.sprite.dest_x) <<< 1) + 18'(dwz);
         s1_cy2_ff   <= (18'(vtx_in.sprite.dest_y) <<< 1) + 18'(dhz);
         s1_ox_ff    <= vtx_in.corner[0] ? dwz : -dwz;
         s1_oy_ff    <= vtx_in.corner[1] ? dhz : -dhz;
         s1_su_ff    <= vtx_in.corner[0] ?
                        ({1'b0, vtx_in.sprite.src_x} + {1'b0, vtx_in.sprite.src_width}) :
                        {1'b0, vtx_in.sprite.src_x};
         s1_sv_ff    <= vtx_in.corner[1] ?
                        ({1'b0, vtx_in.sprite.src_y} + {1'b0, vtx_in.sprite.src_height}) :
                        {1'b0, vtx_in.sprite.src_y};
         s1_color_ff <= vtx_in.sprite.color_rgba;
         s1_last_ff  <= vtx_in.last;
      end
   end

   // ---- stage 2: rotation products
   logic               s2_valid_ff;
   logic signed [32:0] s2_cox_ff, s2_soy_ff, s2_sox_ff, s2_coy_ff;
   logic signed [17:0] s2_cx2_ff, s2_cy2_ff;
   logic [16:0]        s2_su_ff, s2_sv_ff;
   logic [31:0]        s2_color_ff;
   logic               s2_last_ff;
   logic signed [32:0] p_cox, p_soy, p_sox, p_coy;

   always_comb begin
      p_cox = s1_cos_ff * s1_ox_ff;
      p_soy = s1_sin_ff * s1_oy_ff;
      p_sox = s1_sin_ff * s1_ox_ff;
      p_coy = s1_cos_ff * s1_oy_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (advance) begin
         s2_cox_ff   <= p_cox;
         s2_soy_ff   <= p_soy;
         s2_sox_ff   <= p_sox;
         s2_coy_ff   <= p_coy;
         s2_cx2_ff   <= s1_cx2_ff;
         s2_cy2_ff   <= s1_cy2_ff;
         s2_su_ff    <= s1_su_ff;
         s2_sv_ff    <= s1_sv_ff;
         s2_color_ff <= s1_color_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // ---- stage 3: corner position (doubled pixels, Q14), UV numerators
   logic               s3_valid_ff;
   logic signed [34:0] s3_px_ff, s3_py_ff;
   logic [32:0]        s3_au_ff, s3_av_ff;
   logic [31:0]        s3_color_ff;
   logic               s3_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (advance) begin
         s3_px_ff    <= (35'(s2_cx2_ff) <<< 14) + 35'(s2_cox_ff) - 35'(s2_soy_ff);
         s3_py_ff    <= (35'(s2_cy2_ff) <<< 14) + 35'(s2_sox_ff) + 35'(s2_coy_ff);
         s3_au_ff    <= (33'(s2_su_ff) << SCALE_SH) + 33'(cfg.tw);
         s3_av_ff    <= (33'(s2_sv_ff) << SCALE_SH) + 33'(cfg.th);
         s3_color_ff <= s2_color_ff;
         s3_last_ff  <= s2_last_ff;
      end
   end

   // ---- stage 4: NDC numerator with half-divisor bias, floor by 2^15
   logic               s4_valid_ff;
   logic signed [36:0] s4_nx_ff, s4_ny_ff;
   logic [NUM_W-1:0]   s4_nu_ff, s4_nv_ff;
   logic [31:0]        s4_color_ff;
   logic               s4_last_ff;
   logic signed [51:0] vw14, vh14, ax, ay;
   logic [32:0]        lim_u, lim_v;

   always_comb begin
      vw14  = 52'(signed'({1'b0, cfg.vw})) <<< 14;
      vh14  = 52'(signed'({1'b0, cfg.vh})) <<< 14;
      ax    = ((52'(s3_px_ff) - vw14) <<< SCALE_SH) + vw14;
      ay    = ((vh14 - 52'(s3_py_ff)) <<< SCALE_SH) + vh14;
      // UV divides by 2*size; clamp keeps the quotient within 16 bits
      lim_u = 33'(cfg.tw) << 17;
      lim_v = 33'(cfg.th) << 17;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (advance) begin
         s4_nx_ff    <= 37'(ax >>> 15);
         s4_ny_ff    <= 37'(ay >>> 15);
         s4_nu_ff    <= NUM_W'((s3_au_ff >= lim_u) ? (lim_u - 33'd1) : s3_au_ff);
         s4_nv_ff    <= NUM_W'((s3_av_ff >= lim_v) ? (lim_v - 33'd1) : s3_av_ff);
         s4_color_ff <= s3_color_ff;
         s4_last_ff  <= s3_last_ff;
      end
   end

   // ---- stage 5: clamp to +-size*2^16 and offset to non-negative
   num_type            s5_ff;
   logic signed [36:0] lim_x, lim_y, cx, cy;

   always_comb begin
      lim_x = 37'(signed'({1'b0, cfg.vw})) <<< 16;
      lim_y = 37'(signed'({1'b0, cfg.vh})) <<< 16;
      priority if (s4_nx_ff < -lim_x)       cx = -lim_x;
      else if (s4_nx_ff > lim_x - 37'sd1)   cx = lim_x - 37'sd1;
      else                                  cx = s4_nx_ff;
      priority if (s4_ny_ff < -lim_y)       cy = -lim_y;
      else if (s4_ny_ff > lim_y - 37'sd1)   cy = lim_y - 37'sd1;
      else                                  cy = s4_ny_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_ff.valid <= 1'b0;
      end else if (advance) begin
         s5_ff.valid <= s4_valid_ff;
      end
      if (advance) begin
         s5_ff.num_x <= NUM_W'(cx + lim_x);
         s5_ff.num_y <= NUM_W'(cy + lim_y);
         s5_ff.num_u <= s4_nu_ff;
         s5_ff.num_v <= s4_nv_ff;
         s5_ff.color <= s4_color_ff;
         s5_ff.last  <= s4_last_ff;
      end
   end

   assign num_out = s5_ff;

`ifndef NO_ASSERTIONS
   a_num_x_range: assert property (@(posedge clock) disable iff (reset)
      s5_ff.valid |-> (s5_ff.num_x < (NUM_W'(cfg.vw) << QUO_W)))
      else $error("x numerator exceeds divider range");
   a_num_u_range: assert property (@(posedge clock) disable iff (reset)
      s5_ff.valid |-> (s5_ff.num_u < (NUM_W'(cfg.tw) << (QUO_W + 1))))
      else $error("u numerator exceeds divider range");
`endif

endmodule

### src/rotated_sprite_quad_setup.sv
// Path: a request is registered in the sequencer, then its vertices pass the
//   geometry stages, the divider stages and the output register to rsp_*.
// Throughput: one vertex per cycle while rsp_stall stays low, set by
//   the single vertex output; the sequencer takes the next request as the
//   sixth vertex of the current one issues.
// Reset: synchronous; clears all valid bits and loads the default registers.
// ----------------------------------------------------------------------------
// rotated_sprite_quad_setup: rotated sprite to two-triangle vertex setup
// Rotates the destination rectangle about its centre, maps corners to NDC and
// the source rectangle to UV, emitting six vertices per sprite request.
// ----------------------------------------------------------------------------
module rotated_sprite_quad_setup #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int OUT_FRAC_BITS   = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   // sprite requests
   input  logic                          req_valid,
   output logic                          req_stall,
   input  rsq_pkg::req_type              req_data,
   // vertex results
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output rsq_pkg::rsp_type              rsp_data,
   // register writes
   input  logic                          csr_write,
   input  logic [1:0]                    csr_index,
   input  logic [rsq_pkg::CFG_W-1:0]     csr_data
);
   import rsq_pkg::*;

   // ---------------------------------------------------------------- registers
   logic [CFG_W-1:0] vw_ff, vh_ff, tw_ff, th_ff;
   cfg_type          cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         vw_ff <= VIEWPORT_WIDTH_RST;
         vh_ff <= VIEWPORT_HEIGHT_RST;
         tw_ff <= TEXTURE_WIDTH_RST;
         th_ff <= TEXTURE_HEIGHT_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_VIEWPORT_WIDTH:  vw_ff <= csr_data;
            CSR_VIEWPORT_HEIGHT: vh_ff <= csr_data;
            CSR_TEXTURE_WIDTH:   tw_ff <= csr_data;
            CSR_TEXTURE_HEIGHT:  th_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // a zero size divides as one
   always_comb begin
      cfg.vw = (vw_ff == '0) ? CFG_W'(1) : vw_ff;
      cfg.vh = (vh_ff == '0) ? CFG_W'(1) : vh_ff;
      cfg.tw = (tw_ff == '0) ? CFG_W'(1) : tw_ff;
      cfg.th = (th_ff == '0) ? CFG_W'(1) : th_ff;
   end

   // ---------------------------------------------------------------- pipeline
   // The whole pipe moves as one: it advances whenever the output register is
   // empty or being taken. Valid bits ride alongside so bubbles stay put.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    advance;

   assign advance = !rsp_valid_ff || !rsp_stall;

   vtx_type exp_vtx;
   num_type num;

   rsq_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .vtx       (exp_vtx)
   );

   rsq_geom #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .OUT_FRAC_BITS   (OUT_FRAC_BITS)
   ) u_geom (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .vtx_in  (exp_vtx),
      .num_out (num)
   );

   // x/y divide by the viewport size; u/v by twice the texture size, which
   // folds the round-to-nearest half into the numerator
   logic [QUO_W-1:0] quo_x, quo_y, quo_u, quo_v;

   rsq_div_pipe #(.DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_x (
      .clock (clock), .advance (advance),
      .den (DEN_W'(cfg.vw)), .num (num.num_x), .quo (quo_x)
   );
   rsq_div_pipe #(.DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_y (
      .clock (clock), .advance (advance),
      .den (DEN_W'(cfg.vh)), .num (num.num_y), .quo (quo_y)
   );
   rsq_div_pipe #(.DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_u (
      .clock (clock), .advance (advance),
      .den ({cfg.tw, 1'b0}), .num (num.num_u), .quo (quo_u)
   );
   rsq_div_pipe #(.DEN_W(DEN_W), .QUO_W(QUO_W)) u_div_v (
      .clock (clock), .advance (advance),
      .den ({cfg.th, 1'b0}), .num (num.num_v), .quo (quo_v)
   );

   // side band matching the divider depth
   logic        dly_valid_ff [QUO_W];
   logic [31:0] dly_color_ff [QUO_W];
   logic        dly_last_ff  [QUO_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QUO_W; i++) dly_valid_ff[i] <= 1'b0;
      end else if (advance) begin
         dly_valid_ff[0] <= num.valid;
         for (int i = 1; i < QUO_W; i++) dly_valid_ff[i] <= dly_valid_ff[i-1];
      end
      if (advance) begin
         dly_color_ff[0] <= num.color;
         dly_last_ff[0]  <= num.last;
         for (int i = 1; i < QUO_W; i++) begin
            dly_color_ff[i] <= dly_color_ff[i-1];
            dly_last_ff[i]  <= dly_last_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------- output
   // NDC quotients carry a 2^16 offset from the numerator shift.
   function automatic logic signed [15:0] sat_s16(input logic [QUO_W-1:0] q);
      logic signed [QUO_W:0] v;
      v = signed'({1'b0, q}) - (QUO_W + 1)'(1 << (QUO_W - 1));
      priority if (v > (QUO_W + 1)'(32767))       return 16'sh7fff;
      else if (v < -(QUO_W + 1)'(32768))          return 16'sh8000;
      else                                        return 16'(v);
   endfunction

   rsp_type rsp_next;

   always_comb begin
      rsp_next.vertex_x     = sat_s16(quo_x);
      rsp_next.vertex_y     = sat_s16(quo_y);
      rsp_next.vertex_color = dly_color_ff[QUO_W-1];
      rsp_next.tex_u        = quo_u[15:0];
      rsp_next.tex_v        = quo_v[15:0];
      rsp_next.last_vertex  = dly_last_ff[QUO_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dly_valid_ff[QUO_W-1];
      end
      if (advance) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_take_starts_sprite: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> exp_vtx.valid)
      else $error("accepted request did not start vertex issue");
   a_take_needs_advance: assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> advance)
      else $error("request taken while pipeline held");
   a_vertex_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (advance && dly_valid_ff[QUO_W-1]) |=> rsp_valid)
      else $error("vertex lost before output register");
`endif

endmodule
